@@ rtl/bfm_pkg.sv @@
`timescale 1ns / 1ps

package bfm_pkg;

    // Line store geometry
    localparam int MAX_COLS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);      // column index
    localparam int COLS_W     = 11;                    // frame_cols register
    localparam int ROWS_W     = 12;                    // frame_rows register
    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 12;                    // nine 8-bit pixels

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

    // Register reset values
    localparam logic [COLS_W-1:0] FRAME_COLS_RST = 11'd1024;
    localparam logic [ROWS_W-1:0] FRAME_ROWS_RST = 12'd12;

    // Smallest legal frame side
    localparam logic [COLS_W-1:0] MIN_COLS = 11'd3;
    localparam logic [ROWS_W-1:0] MIN_ROWS = 12'd3;
    localparam logic [COLS_W-1:0] TOP_COLS = COLS_W'(MAX_COLS);

    // Output queue depth: output word, one in compute, one spare
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 2;

    // Reciprocal of 9 in Q15: 9 * 3641 = 32769, exact floor for sums below 2^15
    localparam int          DIV9_SHIFT = 15;
    localparam logic [11:0] DIV9_RECIP = 12'd3641;

    typedef struct packed {
        logic             frame_last;
        logic [PIX_W-1:0] pixel_out;
    } result_t;

    // floor(sum / 9) for sums up to 9 * 255
    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [2*SUM_W-1:0] prod;
        prod = {{SUM_W{1'b0}}, sum} * {{SUM_W{1'b0}}, DIV9_RECIP};
        return prod[DIV9_SHIFT +: PIX_W];
    endfunction

endpackage

@@ rtl/bfm_out_fifo.sv @@
`timescale 1ns / 1ps

module bfm_out_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  bfm_pkg::result_t          push_data,
    input  logic                      pop,
    output bfm_pkg::result_t          head,
    output logic                      not_empty,
    output logic [bfm_pkg::OQ_CNT_W-1:0] count
);
    import bfm_pkg::*;

    result_t              entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]  count_reg, count_next;

    // pointer wrap at queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

@@ rtl/box_filter_3x3_mean_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)   tuser          tlast
// s_axis    in   [7:0] pixel_in       [0] frame_start  -
// m_axis    out  [7:0] pixel_out      -              frame_last
// cfg       in   index 0: frame_cols [10:0], index 1: frame_rows [11:0]
//
// One pixel per clock sustained while s_tready is high; a result passes the capture
// registers, whose line store read is registered (one 1024x16 memory, one read and
// one write per cycle), then the combinational sum/divide into the output queue.
// Border pixels are consumed and give no word. Reset clears counters, window,
// registers and the output queue; the line store is not cleared.
// s_tready drops only when the three-word output queue would fill under stall.

module box_filter_3x3_mean_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  logic                            s_tuser,   // [0] frame_start
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] pixel_out
    output logic                            m_tlast,
    // configuration
    input  logic                            cfg_we,
    input  logic [bfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bfm_pkg::*;

    logic [COLS_W-1:0] frame_cols_reg;
    logic [ROWS_W-1:0] frame_rows_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROWS_W-1:0] row_reg, row_next;

    logic [COLS_W-1:0] cols_used;
    logic [ROWS_W-1:0] rows_used;
    logic [COLS_W-1:0] c0, c1, c_inc;
    logic [ROWS_W:0]   r0, r1, r2, r_inc;
    logic              emit_next, last_next;
    logic              in_fire;

    // compute stage
    logic              s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [2*PIX_W-1:0] line_rd_reg;                 // {upper, middle}
    logic [2*PIX_W-1:0] line_mem [MAX_COLS];

    logic [PIX_W-1:0]  win_reg [6];                  // 0..2: col c-2, 3..5: col c-1
    logic [PIX_W-1:0]  top_px, mid_px;
    logic [SUM_W-1:0]  win_sum;

    result_t              res_word, head_word;
    logic                 oq_push, oq_pop, oq_not_empty;
    logic [OQ_CNT_W-1:0]  oq_count;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cols_reg <= FRAME_COLS_RST;
            frame_rows_reg <= FRAME_ROWS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_COLS: frame_cols_reg <= cfg_wdata[COLS_W-1:0];
                REG_FRAME_ROWS: frame_rows_reg <= cfg_wdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp frame size to legal range
    always_comb begin
        cols_used = frame_cols_reg;
        if (frame_cols_reg < MIN_COLS) begin
            cols_used = MIN_COLS;
        end else if (frame_cols_reg > TOP_COLS) begin
            cols_used = TOP_COLS;
        end
        rows_used = (frame_rows_reg < MIN_ROWS) ? MIN_ROWS : frame_rows_reg;
    end

    // position of the incoming pixel and counters for the next one
    always_comb begin
        c0 = s_tuser ? '0 : {1'b0, col_reg};
        r0 = s_tuser ? '0 : {1'b0, row_reg};
        if (c0 >= cols_used) begin
            c1 = '0;
            r1 = r0 + 1'b1;
        end else begin
            c1 = c0;
            r1 = r0;
        end
        r2 = (r1 >= {1'b0, rows_used}) ? '0 : r1;

        emit_next = (r2 >= (ROWS_W+1)'(2)) && (c1 >= COLS_W'(2));
        last_next = (r2 == {1'b0, rows_used} - 1'b1) && (c1 == cols_used - 1'b1);

        c_inc = c1 + 1'b1;
        r_inc = r2 + 1'b1;
        if (c_inc >= cols_used) begin
            col_next = '0;
            row_next = (r_inc >= {1'b0, rows_used}) ? '0 : r_inc[ROWS_W-1:0];
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r2[ROWS_W-1:0];
        end
    end

    assign s_tready = ({1'b0, oq_count} + {2'b00, s1_valid_reg & s1_emit_reg})
                      <= (OQ_CNT_W+1)'(OQ_DEPTH - 1);
    assign in_fire  = s_tvalid && s_tready;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_fire;
            if (in_fire) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // capture pixel, issue line store read; a back-to-back hit on the column
    // still being written (restart at column 0) takes the shifted pair directly
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_px_reg   <= s_tdata;
            s1_col_reg  <= c1[COL_W-1:0];
            s1_emit_reg <= emit_next;
            s1_last_reg <= last_next;
            if (s1_valid_reg && (s1_col_reg == c1[COL_W-1:0])) begin
                line_rd_reg <= {line_rd_reg[PIX_W-1:0], s1_px_reg};
            end else begin
                line_rd_reg <= line_mem[c1[COL_W-1:0]];
            end
        end
    end

    // shift line stores: middle moves up, new pixel becomes middle
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= {line_rd_reg[PIX_W-1:0], s1_px_reg};
        end
    end

    assign top_px = line_rd_reg[2*PIX_W-1:PIX_W];
    assign mid_px = line_rd_reg[PIX_W-1:0];

    // window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_valid_reg) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_px;
            win_reg[4] <= mid_px;
            win_reg[5] <= s1_px_reg;
        end
    end

    // nine-pixel sum and mean
    always_comb begin
        win_sum = SUM_W'(top_px) + SUM_W'(mid_px) + SUM_W'(s1_px_reg);
        for (int i = 0; i < 6; i++) begin
            win_sum = win_sum + SUM_W'(win_reg[i]);
        end
        res_word.pixel_out  = div9(win_sum);
        res_word.frame_last = s1_last_reg;
    end

    assign oq_push = s1_valid_reg && s1_emit_reg;
    assign oq_pop  = oq_not_empty && m_tready;

    bfm_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (oq_push),
        .push_data (res_word),
        .pop       (oq_pop),
        .head      (head_word),
        .not_empty (oq_not_empty),
        .count     (oq_count)
    );

    assign m_tvalid = oq_not_empty;
    assign m_tdata  = head_word.pixel_out;
    assign m_tlast  = head_word.frame_last;

endmodule

@@ verif/box_mean_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the register port, predicts every filtered word
// and compares it with what the filter puts out.
module box_mean_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  logic                            s_tuser,   // [0] frame_start
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,   // [7:0] pixel_out
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [bfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              mismatches,
    output int                              words_pending,
    output int                              pixels_taken,
    output int                              words_seen
);
    import bfm_pkg::*;

    // predictor copy of the registers and the neighborhood storage
    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [PIX_W-1:0]  upper_row  [MAX_COLS];
    logic [PIX_W-1:0]  middle_row [MAX_COLS];
    logic [PIX_W-1:0]  win [6];      // [0..2] column c-2, [3..5] column c-1
    int unsigned       col_pos;
    int unsigned       row_pos;
    result_t           expected_means[$];

    int bad_fields;
    int pix_count;
    int word_count;

    assign mismatches   = bad_fields;
    assign pixels_taken = pix_count;
    assign words_seen   = word_count;

    initial begin
        bad_fields = 0;
        pix_count  = 0;
        word_count = 0;
        foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
    end

    // one pixel into the window; queues the mean when a full 3x3 is present
    task automatic predict_mean(input logic [PIX_W-1:0] px, input logic start);
        int unsigned ncols, nrows, c, sum;
        logic [PIX_W-1:0] top_px, mid_px;
        result_t r;
        ncols = cols_reg;
        if (cols_reg < MIN_COLS) ncols = 3;
        if (cols_reg > TOP_COLS) ncols = MAX_COLS;
        nrows = (rows_reg < MIN_ROWS) ? 3 : rows_reg;

        if (start) begin
            col_pos = 0;
            row_pos = 0;
        end
        // limits may have shrunk since the last pixel
        if (col_pos >= ncols) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= nrows) row_pos = 0;

        c      = col_pos;
        top_px = upper_row[c];
        mid_px = middle_row[c];

        if (row_pos >= 2 && c >= 2) begin
            sum = top_px + mid_px + px;
            foreach (win[k]) sum += win[k];
            r.pixel_out  = PIX_W'(sum / 9);
            r.frame_last = (row_pos == nrows - 1) && (c == ncols - 1);
            expected_means.push_back(r);
        end

        upper_row[c]  = mid_px;
        middle_row[c] = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top_px;
        win[4] = mid_px;
        win[5] = px;

        col_pos = c + 1;
        if (col_pos >= ncols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= nrows) row_pos = 0;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            cols_reg = FRAME_COLS_RST;
            rows_reg = FRAME_ROWS_RST;
            foreach (win[k]) win[k] = '0;
            col_pos = 0;
            row_pos = 0;
            expected_means.delete();
        end else begin
            // user keeps register writes to filter idle; not enforced
            if (cfg_we) begin
                if (cfg_index == REG_FRAME_COLS) cols_reg = cfg_wdata[COLS_W-1:0];
                else if (cfg_index == REG_FRAME_ROWS) rows_reg = cfg_wdata[ROWS_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                predict_mean(s_tdata, s_tuser);
                pix_count++;
            end
            // compare the outgoing word with the oldest prediction
            if (m_tvalid && m_tready) begin
                word_count++;
                if (expected_means.size() == 0) begin
                    $error("unexpected word: pixel_out %0d frame_last %0d", m_tdata, m_tlast);
                    bad_fields++;
                end else begin
                    want = expected_means.pop_front();
                    if (m_tdata !== want.pixel_out) begin
                        $error("pixel_out: expected %0d, got %0d", want.pixel_out, m_tdata);
                        bad_fields++;
                    end
                    if (m_tlast !== want.frame_last) begin
                        $error("frame_last: expected %0d, got %0d", want.frame_last, m_tlast);
                        bad_fields++;
                    end
                end
            end
        end
        words_pending <= expected_means.size();
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bfm_pkg::*;

    localparam int STALL_LIMIT  = 4000;   // cycles with no word moving
    localparam int DRAIN_CYCLES = 6;      // covers the filter pipeline

    typedef enum logic [1:0] {GAP_NONE, GAP_SRC, GAP_SNK, GAP_BOTH} gap_mode_e;
    typedef enum logic [1:0] {MIX_FULL, MIX_EDGES, MIX_HIGH, MIX_LOW} pix_mix_e;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int words_pending;
    int pixels_taken;
    int words_seen;

    gap_mode_e gap_mode    = GAP_NONE;
    logic      hold_arm    = 1'b0;
    logic      hold_active = 1'b0;
    int        quiet_cycles = 0;
    int        geometries   = 1;

    box_filter_3x3_mean_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    box_mean_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .pixels_taken  (pixels_taken),
        .words_seen    (words_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls per mode, or a long hold-off
    always @(posedge aclk) begin
        if (hold_active) m_tready <= 1'b0;
        else if (gap_mode == GAP_SNK) m_tready <= ($urandom_range(99) >= 67);
        else if (gap_mode == GAP_BOTH) m_tready <= ($urandom_range(99) >= 9);
        else m_tready <= 1'b1;
    end

    // long hold-off during the first 12x4 frames so the output queue fills
    initial begin
        wait (hold_arm);
        repeat (10) @(posedge aclk);
        hold_active <= 1'b1;
        repeat (80) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] pick_pixel(input pix_mix_e mix);
        case (mix)
            MIX_EDGES: return $urandom_range(1) ? 8'hFF : 8'h00;
            MIX_HIGH:  return 8'($urandom_range(255, 224));
            MIX_LOW:   return 8'($urandom_range(31));
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    // offer one word and hold it until taken
    task automatic send_pixel(input logic [7:0] px, input logic start);
        int unsigned gap_pct;
        gap_pct = (gap_mode == GAP_SRC) ? 67 : (gap_mode == GAP_BOTH) ? 9 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait for every predicted word
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] cols_val,
                             input logic [CFG_DATA_W-1:0] rows_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_COLS;
        cfg_wdata <= cols_val;
        @(posedge aclk);
        cfg_index <= REG_FRAME_ROWS;
        cfg_wdata <= rows_val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        geometries++;
    endtask

    // mostly whole frames, sometimes no start flag (wrap), rare stray restarts
    task automatic run_phase(input logic [CFG_DATA_W-1:0] cols_val,
                             input logic [CFG_DATA_W-1:0] rows_val,
                             input int unsigned n_px, input gap_mode_e mode,
                             input pix_mix_e mix, input bit lead_start);
        int unsigned fcols, frows, frame_px, pos, since_start;
        logic start;
        drain();
        set_frame(cols_val, rows_val);
        gap_mode <= mode;
        fcols = cols_val[COLS_W-1:0];
        if (fcols < 3) fcols = 3;
        if (fcols > MAX_COLS) fcols = MAX_COLS;
        frows = rows_val;
        if (frows < 3) frows = 3;
        frame_px    = fcols * frows;
        since_start = 0;
        for (pos = 0; pos < n_px; pos++) begin
            if (pos == 0) start = lead_start;
            else if (since_start % frame_px == 0) start = ($urandom_range(99) < 70);
            else start = ($urandom_range(199) == 0);
            if (start) since_start = 0;
            send_pixel(pick_pixel(mix), start);
            since_start++;
        end
    endtask

    initial begin
        int i;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FRAME_COLS;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        // part of the first row at the reset geometry: no words expected
        for (i = 0; i < 40; i++) send_pixel(pick_pixel(MIX_FULL), i == 0);
        drain();

        // two 12x4 frames under a long hold-off; writes columns 0 to 11, which the later small geometries use
        set_frame(12'd12, 12'd4);
        hold_arm = 1'b1;
        for (i = 0; i < 96; i++) send_pixel(pick_pixel(MIX_FULL), i == 0);
        drain();

        // directed: clamped 3x3 frames, extremes, wrap without start, restart
        set_frame(12'd0, 12'd2);
        for (i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
        for (i = 0; i < 9; i++) send_pixel(8'h00, 1'b0);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h5A, 1'b0);
        for (i = 0; i < 9; i++) send_pixel(8'(i + 1), i == 0);

        // widest and tallest geometries, register bits all ones
        run_phase(12'hFFF, 12'd3, 60, GAP_BOTH, MIX_FULL, 1'b1);
        run_phase(12'd3, 12'hFFF, 60, GAP_NONE, MIX_EDGES, 1'b1);

        // small random geometries, some continuing mid-frame after the change
        for (i = 0; i < 9; i++) begin
            run_phase(12'($urandom_range(12)), 12'($urandom_range(10)),
                      $urandom_range(50, 25), gap_mode_e'(i % 4),
                      pix_mix_e'($urandom_range(3)), 1'($urandom_range(1)));
        end
        drain();

        $display("Covered %0d pixels in and %0d filtered words out over %0d frame geometries,",
                 pixels_taken, words_seen, geometries);
        $display("clamped and extreme sizes, restarts and all four flow-control mixes included.");
        if (mismatches == 0 && words_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bfm_pkg.sv
rtl/bfm_out_fifo.sv
rtl/box_filter_3x3_mean_unit.sv
verif/box_mean_checker.sv
verif/testbench.sv
